@@ rtl/pwg_pkg.sv @@
// Package with the register index codes shared by the pulse generator and its checker.
package pwg_pkg;

    // Width of the configuration register index.
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t REG_LOW_LEVEL     = 3'd0;
    localparam cfg_index_t REG_HIGH_LEVEL    = 3'd1;
    localparam cfg_index_t REG_DELAY_TIME    = 3'd2;
    localparam cfg_index_t REG_RISE_TIME     = 3'd3;
    localparam cfg_index_t REG_FALL_TIME     = 3'd4;
    localparam cfg_index_t REG_PULSE_WIDTH   = 3'd5;
    localparam cfg_index_t REG_PERIOD_LENGTH = 3'd6;

endpackage

@@ rtl/pwg_div_cell.sv @@
// One restoring division cell: takes one dividend bit and hands the result to the next cell.
module pwg_div_cell #(
    parameter int DW = 32,
    parameter int NW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [NW-1:0] in_quo,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [NW-1:0] out_num,
    output logic [NW-1:0] out_quo,
    output logic [DW-1:0] out_div,
    output logic [SW-1:0] out_side
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic          valid_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] div_reg;
    logic [SW-1:0] side_reg;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        trial    = {in_rem, in_num[NW-1]};
        diff     = trial - {1'b0, in_div};
        fits     = (trial >= {1'b0, in_div});
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    end

    // Valid flag of this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload handed to the neighbor.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= {in_num[NW-2:0], 1'b0};
        quo_reg  <= {in_quo[NW-2:0], fits};
        div_reg  <= in_div;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

@@ rtl/pwg_div_chain.sv @@
// Row of division cells, one quotient bit per cell.
module pwg_div_chain #(
    parameter int DW = 32,
    parameter int NW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic          valid_s [NW+1];
    logic [DW-1:0] rem_s   [NW+1];
    logic [NW-1:0] num_s   [NW+1];
    logic [NW-1:0] quo_s   [NW+1];
    logic [DW-1:0] div_s   [NW+1];
    logic [SW-1:0] side_s  [NW+1];

    // Head of the row.
    assign valid_s[0] = in_valid;
    assign rem_s[0]   = in_rem;
    assign num_s[0]   = in_num;
    assign quo_s[0]   = '0;
    assign div_s[0]   = in_div;
    assign side_s[0]  = in_side;

    // Cells, each feeding its neighbor.
    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        pwg_div_cell #(.DW(DW), .NW(NW), .SW(SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (valid_s[i]),
            .in_rem   (rem_s[i]),
            .in_num   (num_s[i]),
            .in_quo   (quo_s[i]),
            .in_div   (div_s[i]),
            .in_side  (side_s[i]),
            .out_valid(valid_s[i+1]),
            .out_rem  (rem_s[i+1]),
            .out_num  (num_s[i+1]),
            .out_quo  (quo_s[i+1]),
            .out_div  (div_s[i+1]),
            .out_side (side_s[i+1])
        );
    end

    assign out_valid = valid_s[NW];
    assign out_rem   = rem_s[NW];
    assign out_quo   = quo_s[NW];
    assign out_side  = side_s[NW];

endmodule

@@ rtl/pulse_waveform_generator.sv @@
// Top level of the pipelined trapezoidal pulse generator.
//
//   channel   ports                          handshake
//   input     start, busy, sample_time       taken when start high and busy low
//   result    done, wave_value               shown for one cycle with done
//   config    cfg_we, cfg_index, cfg_data    written at each edge with cfg_we high
//
// One item enters every cycle; busy is always low.
// An item passes the entry register, one cell per phase bit in the modulo row, the
// phase and multiply registers, one cell per quotient bit in the ramp division row,
// and the output register.
// Reset clears the valid flags and the configuration registers.
// The receiver cannot stall; each result shows for exactly one cycle.
module pulse_waveform_generator #(
    parameter int TIME_WIDTH  = 32,
    parameter int VALUE_WIDTH = 32,
    localparam int DATA_WIDTH = (TIME_WIDTH > VALUE_WIDTH) ? TIME_WIDTH : VALUE_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [TIME_WIDTH-1:0]        sample_time,
    output logic                         done,
    output logic signed [VALUE_WIDTH-1:0] wave_value,
    input  logic                         cfg_we,
    input  pwg_pkg::cfg_index_t          cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_data
);

    localparam int MW = VALUE_WIDTH + 1;
    localparam int PW = MW + TIME_WIDTH;
    localparam int SIDE_W = 2 * VALUE_WIDTH + 2;

    logic signed [VALUE_WIDTH-1:0] low_reg;
    logic signed [VALUE_WIDTH-1:0] high_reg;
    logic [TIME_WIDTH-1:0] delay_reg;
    logic [TIME_WIDTH-1:0] rise_reg;
    logic [TIME_WIDTH-1:0] fall_reg;
    logic [TIME_WIDTH-1:0] width_reg;
    logic [TIME_WIDTH-1:0] period_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg    <= '0;
            high_reg   <= '0;
            delay_reg  <= '0;
            rise_reg   <= '0;
            fall_reg   <= '0;
            width_reg  <= '0;
            period_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwg_pkg::REG_LOW_LEVEL:     low_reg    <= cfg_data[VALUE_WIDTH-1:0];
                pwg_pkg::REG_HIGH_LEVEL:    high_reg   <= cfg_data[VALUE_WIDTH-1:0];
                pwg_pkg::REG_DELAY_TIME:    delay_reg  <= cfg_data[TIME_WIDTH-1:0];
                pwg_pkg::REG_RISE_TIME:     rise_reg   <= cfg_data[TIME_WIDTH-1:0];
                pwg_pkg::REG_FALL_TIME:     fall_reg   <= cfg_data[TIME_WIDTH-1:0];
                pwg_pkg::REG_PULSE_WIDTH:   width_reg  <= cfg_data[TIME_WIDTH-1:0];
                pwg_pkg::REG_PERIOD_LENGTH: period_reg <= cfg_data[TIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Entry stage: compare against the delay and form the elapsed time.
    logic                  in_valid_reg;
    logic                  in_low_reg;
    logic [TIME_WIDTH-1:0] in_elapsed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_low_reg     <= (sample_time <= delay_reg);
        in_elapsed_reg <= sample_time - delay_reg;
    end

    // Modulo row: remainder of the elapsed time by the period.
    logic                  mod_valid;
    logic [TIME_WIDTH-1:0] mod_rem;
    logic [TIME_WIDTH-1:0] mod_quo;
    logic                  mod_low;

    pwg_div_chain #(.DW(TIME_WIDTH), .NW(TIME_WIDTH), .SW(1)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_rem   ('0),
        .in_num   (in_elapsed_reg),
        .in_div   (period_reg),
        .in_side  (in_low_reg),
        .out_valid(mod_valid),
        .out_rem  (mod_rem),
        .out_quo  (mod_quo),
        .out_side (mod_low)
    );

    // Phase stage: pick delay, rise, plateau, fall or rest.
    logic [TIME_WIDTH-1:0] e1;
    logic [TIME_WIDTH-1:0] e2;
    logic                  ph_direct;
    logic [VALUE_WIDTH-1:0] ph_value;
    logic signed [VALUE_WIDTH-1:0] ph_from;
    logic signed [VALUE_WIDTH-1:0] ph_to;
    logic [TIME_WIDTH-1:0] ph_num;
    logic [TIME_WIDTH-1:0] ph_den;
    logic                  ph_up;
    logic [MW-1:0]         ph_mag;

    always_comb
    begin
        e1        = mod_rem - rise_reg;
        e2        = e1 - width_reg;
        ph_direct = 1'b1;
        ph_value  = low_reg;
        ph_from   = low_reg;
        ph_to     = high_reg;
        ph_num    = mod_rem;
        ph_den    = rise_reg;
        priority if (mod_low)
        begin
            ph_value = low_reg;
        end
        else if (mod_rem <= rise_reg)
        begin
            ph_direct = (rise_reg == '0) || (mod_rem == rise_reg);
            ph_value  = high_reg;
        end
        else if (e1 <= width_reg)
        begin
            ph_value = high_reg;
        end
        else if (e2 <= fall_reg)
        begin
            ph_direct = (fall_reg == '0) || (e2 == fall_reg);
            ph_value  = low_reg;
            ph_from   = high_reg;
            ph_to     = low_reg;
            ph_num    = e2;
            ph_den    = fall_reg;
        end
        else
        begin
            ph_value = low_reg;
        end
        ph_up  = (ph_to >= ph_from);
        ph_mag = ph_up ? ({ph_to[VALUE_WIDTH-1], ph_to} - {ph_from[VALUE_WIDTH-1], ph_from})
                       : ({ph_from[VALUE_WIDTH-1], ph_from} - {ph_to[VALUE_WIDTH-1], ph_to});
    end

    logic                   p_valid_reg;
    logic                   p_direct_reg;
    logic [VALUE_WIDTH-1:0] p_value_reg;
    logic [VALUE_WIDTH-1:0] p_from_reg;
    logic                   p_up_reg;
    logic [MW-1:0]          p_mag_reg;
    logic [TIME_WIDTH-1:0]  p_num_reg;
    logic [TIME_WIDTH-1:0]  p_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= mod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_direct_reg <= ph_direct;
        p_value_reg  <= ph_value;
        p_from_reg   <= ph_from;
        p_up_reg     <= ph_up;
        p_mag_reg    <= ph_mag;
        p_num_reg    <= ph_num;
        p_den_reg    <= ph_den;
    end

    // Multiply stage: ramp span times elapsed ramp time.
    logic                   m_valid_reg;
    logic [PW-1:0]          m_prod_reg;
    logic [TIME_WIDTH-1:0]  m_den_reg;
    logic [SIDE_W-1:0]      m_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_prod_reg <= PW'(p_mag_reg) * PW'(p_num_reg);
        m_den_reg  <= p_den_reg;
        m_side_reg <= {p_direct_reg, p_value_reg, p_from_reg, p_up_reg};
    end

    // Ramp division row: the upper product bits are already below the divisor.
    logic              d_valid;
    logic [TIME_WIDTH-1:0] d_rem;
    logic [MW-1:0]     d_quo;
    logic [SIDE_W-1:0] d_side;

    pwg_div_chain #(.DW(TIME_WIDTH), .NW(MW), .SW(SIDE_W)) u_ramp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (m_valid_reg),
        .in_rem   (m_prod_reg[PW-1:MW]),
        .in_num   (m_prod_reg[MW-1:0]),
        .in_div   (m_den_reg),
        .in_side  (m_side_reg),
        .out_valid(d_valid),
        .out_rem  (d_rem),
        .out_quo  (d_quo),
        .out_side (d_side)
    );

    // Output stage: add or subtract the quotient from the ramp start, or pass the direct value.
    logic                   f_direct;
    logic [VALUE_WIDTH-1:0] f_value;
    logic [VALUE_WIDTH-1:0] f_from;
    logic                   f_up;
    logic [MW-1:0]          f_sum;
    logic                   done_reg;
    logic [VALUE_WIDTH-1:0] wave_reg;

    always_comb
    begin
        {f_direct, f_value, f_from, f_up} = d_side;
        f_sum = f_up ? ({f_from[VALUE_WIDTH-1], f_from} + d_quo)
                     : ({f_from[VALUE_WIDTH-1], f_from} - d_quo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        wave_reg <= f_direct ? f_value : f_sum[VALUE_WIDTH-1:0];
    end

    assign done       = done_reg;
    assign wave_value = wave_reg;

    logic unused_ok;
    assign unused_ok = ^{mod_quo, d_rem};

endmodule

@@ rtl/pwg_checker.sv @@
// Port checker for the pulse generator and its bind to the top level.
module pwg_checker #(
    parameter int TIME_WIDTH  = 32,
    parameter int VALUE_WIDTH = 32
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_we,
    input pwg_pkg::cfg_index_t cfg_index
);

    localparam int LATENCY = TIME_WIDTH + VALUE_WIDTH + 5;

    // Every accepted item later gives a result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item produced no result");

    // No result appears without an item accepted at the matching edge.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted item");

    // The block never refuses an item.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Configuration is to be written by the user only while no item is in flight; the block does not enforce it.
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index <= pwg_pkg::REG_PERIOD_LENGTH)) |-> !(start && !busy))
        else $error("configuration written together with an item");

endmodule

bind pulse_waveform_generator pwg_checker #(
    .TIME_WIDTH (TIME_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
) u_pwg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index)
);
